// ===== sv/lsq_pkg.sv =====
// ----------------------------------------------------------------------------
// Largest square of ones: shared package
// Sizes of the line store and the payload fields, and the write-port bundle
// that the datapath hands to the line store.
// ----------------------------------------------------------------------------
package lsq_pkg;

   localparam int MAX_COLS = 256;
   localparam int COL_W    = $clog2(MAX_COLS);
   localparam int WIDTH_W  = 9;
   localparam int SIDE_W   = 9;
   localparam int AREA_W   = 17;

   typedef struct packed {
      logic              en;
      logic [COL_W-1:0]  addr;
      logic [SIDE_W-1:0] data;
   } lsq_wr_type;

endpackage

// ===== sv/lsq_req_if.sv =====
// ----------------------------------------------------------------------------
// Largest square of ones: request channel
// One matrix cell per request, with a flag on the final cell.
// ----------------------------------------------------------------------------
interface lsq_req_if;
   logic valid;
   logic ready;
   logic cell_req;
   logic last;

   modport source (output valid, output cell_req, output last, input ready);
   modport sink   (input valid, input cell_req, input last, output ready);
endinterface

// ===== sv/lsq_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Largest square of ones: response channel
// Area and side of the largest all-ones square of one matrix.
// ----------------------------------------------------------------------------
interface lsq_rsp_if
   import lsq_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [AREA_W-1:0] largest_area;
   logic [SIDE_W-1:0] largest_side;

   modport source (output valid, output largest_area, output largest_side, input ready);
   modport sink   (input valid, input largest_area, input largest_side, output ready);
endinterface

// ===== sv/lsq_line_store.sv =====
// ----------------------------------------------------------------------------
// Largest square of ones: line store
// Holds the square sides of the previous row, one entry per column. Reads
// are registered; a read that hits the entry being written in the same cycle
// returns the new data. Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module lsq_line_store
   import lsq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [COL_W-1:0]  rd_addr,
   input  lsq_wr_type        wr,
   output logic [SIDE_W-1:0] rd_data
);

   logic [SIDE_W-1:0] mem_ff [MAX_COLS];
   logic [MAX_COLS-1:0] written_ff;
   logic [SIDE_W-1:0] mem_rd_ff;
   logic [SIDE_W-1:0] fwd_data_ff;
   logic              rd_written_ff;
   logic              fwd_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         mem_rd_ff   <= mem_ff[rd_addr];
         fwd_data_ff <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
         fwd_ff        <= 1'b0;
      end else begin
         if (wr.en) begin
            written_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_written_ff <= written_ff[rd_addr];
            fwd_ff        <= wr.en && (wr.addr == rd_addr);
         end
      end
   end

   always_comb begin
      if (fwd_ff) begin
         rd_data = fwd_data_ff;
      end else if (rd_written_ff) begin
         rd_data = mem_rd_ff;
      end else begin
         rd_data = '0;
      end
   end

endmodule

// ===== sv/largest_square_of_ones.sv =====
// ----------------------------------------------------------------------------
// Largest square of ones: top level
// Streams a binary matrix row by row and reports the largest all-ones square.
// ----------------------------------------------------------------------------
// The block takes one cell per clock cycle with no gaps of its own: a new
// request is accepted every cycle while results are being taken. Each cell
// reads the previous row's side from a 256-entry line store in the cycle it
// is accepted and computes and writes its own side in the compute stage, so the
// read-modify-write of the line store sets the one-cycle rate. The response
// for a cell flagged last is registered as that cell leaves the compute stage;
// if a response is still waiting to be taken, the last cell stays in the compute
// stage and requests stall until the output register frees. The row width
// register may be changed between requests and takes effect at the next cell.
module largest_square_of_ones
   import lsq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   lsq_req_if.sink            req_ch,
   lsq_rsp_if.source          rsp_ch,
   input  logic               csr_write_enable,
   input  logic [WIDTH_W-1:0] csr_write_data
);

   logic [WIDTH_W-1:0] row_width_ff;
   logic [WIDTH_W-1:0] width_eff;

   logic [COL_W-1:0]   column_index_ff, column_index_in;
   logic               first_row_ff, first_row_in;
   logic               col_wrap;
   logic [COL_W-1:0]   col0;
   logic               first0;
   logic [WIDTH_W-1:0] col_inc;
   logic               accept;

   logic               s1_valid_ff;
   logic               s1_cell_ff;
   logic               s1_last_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic               s1_first_ff;
   logic               s1_fire;

   logic [SIDE_W-1:0]  left_ff;
   logic [SIDE_W-1:0]  diag_ff;
   logic [SIDE_W-1:0]  best_ff;
   logic [SIDE_W-1:0]  rd_data;
   logic [SIDE_W-1:0]  up, left, diag, min_ul, min_all, side, best_new;
   lsq_wr_type         wr;

   logic               rsp_valid_ff;
   logic [AREA_W-1:0]  rsp_area_ff;
   logic [SIDE_W-1:0]  rsp_side_ff;
   logic               rsp_free;

   // Width register and its effective value.
   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= WIDTH_W'(1);
      end else if (csr_write_enable) begin
         row_width_ff <= csr_write_data;
      end
   end

   always_comb begin
      if (row_width_ff == '0) begin
         width_eff = WIDTH_W'(1);
      end else if (row_width_ff > WIDTH_W'(MAX_COLS)) begin
         width_eff = WIDTH_W'(MAX_COLS);
      end else begin
         width_eff = row_width_ff;
      end
   end

   // Stage 0: column tracking and the line store read.
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;
   assign s1_fire      = s1_valid_ff && (!s1_last_ff || rsp_free);
   assign req_ch.ready = !s1_valid_ff || s1_fire;
   assign accept       = req_ch.valid && req_ch.ready;

   // A narrower width written mid-matrix can leave the column past the row end.
   assign col_wrap = {1'b0, column_index_ff} >= width_eff;
   assign col0     = col_wrap ? '0 : column_index_ff;
   assign first0   = col_wrap ? 1'b0 : first_row_ff;
   assign col_inc  = {1'b0, col0} + WIDTH_W'(1);

   always_comb begin
      column_index_in = column_index_ff;
      first_row_in    = first_row_ff;
      if (accept) begin
         if (req_ch.last) begin
            column_index_in = '0;
            first_row_in    = 1'b1;
         end else if (col_inc >= width_eff) begin
            column_index_in = '0;
            first_row_in    = 1'b0;
         end else begin
            column_index_in = col_inc[COL_W-1:0];
            first_row_in    = first0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_index_ff <= '0;
         first_row_ff    <= 1'b1;
         s1_valid_ff     <= 1'b0;
      end else begin
         column_index_ff <= column_index_in;
         first_row_ff    <= first_row_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cell_ff  <= req_ch.cell_req;
         s1_last_ff  <= req_ch.last;
         s1_col_ff   <= col0;
         s1_first_ff <= first0;
      end
   end

   assign wr.en   = s1_fire;
   assign wr.addr = s1_col_ff;
   assign wr.data = side;

   lsq_line_store u_line_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (col0),
      .wr      (wr),
      .rd_data (rd_data)
   );

   // Stage 1: side of the current cell from its three neighbors.
   always_comb begin
      up      = s1_first_ff ? '0 : rd_data;
      left    = (s1_col_ff == '0) ? '0 : left_ff;
      diag    = (s1_first_ff || s1_col_ff == '0) ? '0 : diag_ff;
      min_ul  = (left < up) ? left : up;
      min_all = (diag < min_ul) ? diag : min_ul;
      side    = s1_cell_ff ? min_all + SIDE_W'(1) : '0;
      best_new = (side > best_ff) ? side : best_ff;
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         left_ff <= side;
         diag_ff <= up;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else if (s1_fire) begin
         best_ff <= s1_last_ff ? '0 : best_new;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && s1_last_ff) begin
         rsp_side_ff <= best_new;
         rsp_area_ff <= AREA_W'(best_new) * AREA_W'(best_new);
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.largest_area = rsp_area_ff;
   assign rsp_ch.largest_side = rsp_side_ff;

   // A response appears only after the last cell of a matrix left stage 1.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && s1_last_ff))
      else $error("response without a final cell");

   // A stalled cell holds its column until it can complete.
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_fire) |=> (s1_valid_ff && $stable(s1_col_ff)))
      else $error("stalled cell lost");

   // No side can exceed the widest row.
   a_best_range: assert property (@(posedge clock) disable iff (reset)
      best_ff <= SIDE_W'(MAX_COLS))
      else $error("best side out of range");

   // The reported area is the square of the reported side.
   a_area: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_area_ff == AREA_W'(rsp_side_ff) * AREA_W'(rsp_side_ff)))
      else $error("area does not match side");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Largest square of ones: block-level regression
// Streams binary matrices into the block, recomputes the largest all-ones
// square with a line-store recurrence kept here, and compares every response
// field by field. Covers the row width register at its extremes, width
// changes inside a matrix, early ends, random stalls and a solid 16 by 16
// square.
// ----------------------------------------------------------------------------
module testbench
   import lsq_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int RANDOM_CELLS   = 1300;
   localparam int IDLE_PERCENT   = 28;
   localparam int SQUARE_COLS    = 16;
   localparam int SIDE_LIMIT     = 2**SIDE_W - 1;
   localparam int AREA_LIMIT     = 2**AREA_W - 1;

   typedef struct packed {
      logic [AREA_W-1:0] area;
      logic [SIDE_W-1:0] side;
   } square_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_write_enable;
   logic [WIDTH_W-1:0] csr_write_data;

   lsq_req_if req_bus ();
   lsq_rsp_if rsp_bus ();

   largest_square_of_ones i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_bus),
      .rsp_ch           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5ns clock = ~clock;

   // Square tracker: a copy of the block's state, advanced on every request.
   logic [SIDE_W-1:0]  line_sides [MAX_COLS];
   logic [WIDTH_W-1:0] width_setting;
   int unsigned        col_pos;
   bit                 top_row;
   int unsigned        left_val;
   int unsigned        diag_val;
   int unsigned        best_val;
   square_type         pending_squares [$];
   square_type         oldest_square;

   int unsigned errors       = 0;
   int unsigned cells_sent   = 0;
   int unsigned squares_seen = 0;
   int unsigned idle_cycles  = 0;
   bit          gaps_on      = 1'b0;
   bit          stalls_on    = 1'b0;

   function automatic void clear_matrix();
      col_pos  = 0;
      top_row  = 1'b1;
      left_val = 0;
      diag_val = 0;
      best_val = 0;
   endfunction

   function automatic void track_cell(input logic cell_bit, input logic last_flag);
      int unsigned w;
      int unsigned up;
      int unsigned lft;
      int unsigned dg;
      int unsigned sd;
      int unsigned area;
      square_type  sq;
      w = (width_setting == '0) ? 1 : 32'(width_setting);
      if (w > MAX_COLS) w = MAX_COLS;
      // A width that shrank under the current column starts a new row.
      if (col_pos >= w) begin
         col_pos = 0;
         top_row = 1'b0;
      end
      up  = top_row ? 0 : 32'(line_sides[col_pos[COL_W-1:0]]);
      lft = (col_pos == 0) ? 0 : left_val;
      dg  = (top_row || col_pos == 0) ? 0 : diag_val;
      if (cell_bit) begin
         sd = up;
         if (lft < sd) sd = lft;
         if (dg < sd) sd = dg;
         sd = (sd >= SIDE_LIMIT) ? SIDE_LIMIT : sd + 1;
      end else begin
         sd = 0;
      end
      line_sides[col_pos[COL_W-1:0]] = SIDE_W'(sd);
      diag_val = up;
      left_val = sd;
      if (sd > best_val) best_val = sd;
      if (col_pos + 1 >= w) begin
         col_pos = 0;
         top_row = 1'b0;
      end else begin
         col_pos++;
      end
      if (last_flag) begin
         area = best_val * best_val;
         if (area > AREA_LIMIT) area = AREA_LIMIT;
         sq.area = AREA_W'(area);
         sq.side = SIDE_W'(best_val);
         pending_squares.push_back(sq);
         clear_matrix();
      end
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      errors++;
      if (errors <= 20)
         $display("mismatch: %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
   endtask

   // Tracks requests and register writes, then checks responses. A response
   // always comes after its last cell has been accepted, so the order is safe.
   always @(posedge clock) begin
      if (reset) begin
         width_setting = 1;
         clear_matrix();
         foreach (line_sides[i]) line_sides[i] = '0;
      end else begin
         if (csr_write_enable) width_setting = csr_write_data;
         if (req_bus.valid && req_bus.ready) begin
            cells_sent++;
            track_cell(req_bus.cell_req, req_bus.last);
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            squares_seen++;
            if (pending_squares.size() == 0) begin
               report_mismatch("response with no matrix pending",
                               32'(rsp_bus.largest_side), 0);
            end else begin
               oldest_square = pending_squares.pop_front();
               if (rsp_bus.largest_area !== oldest_square.area)
                  report_mismatch("largest_area", 32'(rsp_bus.largest_area),
                                  32'(oldest_square.area));
               if (rsp_bus.largest_side !== oldest_square.side)
                  report_mismatch("largest_side", 32'(rsp_bus.largest_side),
                                  32'(oldest_square.side));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_write_enable || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_bus.ready <= !stalls_on || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Called at a rising edge; returns at the edge where the request is taken.
   // Valid stays high for a following request and drops only on a gap or in settle.
   task automatic send_cell(input logic cell_bit, input logic last_flag);
      while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.cell_req <= cell_bit;
      req_bus.last     <= last_flag;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_squares.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_row_width(input logic [WIDTH_W-1:0] value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_cells(input int unsigned count, input int unsigned density);
      for (int unsigned k = 0; k < count; k++)
         send_cell($urandom_range(99) < density, k == count - 1);
   endtask

   task automatic test_single_column();
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      send_cell(1'b0, 1'b1);
      send_cell(1'b1, 1'b1);
      send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b1);
   endtask

   task automatic test_register_extremes();
      // A width of zero behaves as a single column.
      write_row_width(9'd0);
      send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b1);
      write_row_width(9'h1FF);
      send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b1);
      write_row_width(9'd256);
      send_cell(1'b0, 1'b0);
      send_cell(1'b1, 1'b1);
   endtask

   task automatic test_small_squares();
      write_row_width(9'd2);
      send_cells(4, 100);
      write_row_width(9'd3);
      send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b0);
      send_cell(1'b0, 1'b0);
      send_cell(1'b1, 1'b1);
   endtask

   task automatic test_width_change_mid_row();
      write_row_width(9'd4);
      send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b0);
      // The current column is now past the new width, so a new row begins.
      write_row_width(9'd2);
      send_cell(1'b1, 1'b0);
      send_cell(1'b1, 1'b1);
   endtask

   task automatic send_random_matrix();
      int unsigned        pick;
      int unsigned        cols;
      int unsigned        total;
      int unsigned        density;
      int unsigned        cut;
      int unsigned        change_at;
      int unsigned        pause_at;
      logic [WIDTH_W-1:0] reg_val;
      pick = $urandom_range(99);
      if (pick < 70) begin
         cols  = $urandom_range(1, 8);
         total = cols * $urandom_range(1, 8);
      end else if (pick < 88) begin
         cols  = $urandom_range(9, 40);
         total = cols * $urandom_range(1, 4);
      end else if (pick < 95) begin
         cols  = $urandom_range(41, 255);
         total = cols + $urandom_range(1, 8);
      end else begin
         cols = 256;
         case ($urandom_range(3))
            0: cols = 1;
            1: cols = 256;
            2: cols = 511;
            default: cols = $urandom_range(257, 511);
         endcase
         total = (cols == 1) ? $urandom_range(1, 8) : 256 + $urandom_range(1, 8);
      end
      reg_val = (cols == 1 && pick >= 95) ? 9'd0 : cols[WIDTH_W-1:0];
      pick = $urandom_range(99);
      density = (pick < 40) ? 100 : (pick < 75) ? 85 : (pick < 90) ? 60 : 20;
      // Some matrices end early, possibly in the middle of a row.
      cut = ($urandom_range(9) == 0) ? $urandom_range(1, total) : total;
      change_at = ($urandom_range(99) < 8) ? $urandom_range(1, cut) : 0;
      pause_at  = ($urandom_range(99) < 5) ? $urandom_range(1, cut) : 0;
      // Keeping the width lets matrices follow each other back to back.
      if (reg_val != width_setting || $urandom_range(1) == 0) write_row_width(reg_val);
      for (int unsigned k = 0; k < cut; k++) begin
         if (k != 0 && k == change_at) write_row_width(WIDTH_W'($urandom_range(1, 16)));
         if (k != 0 && k == pause_at) settle();
         send_cell($urandom_range(99) < density, k == cut - 1);
      end
   endtask

   task automatic test_random_matrices();
      int unsigned start_cells;
      start_cells = cells_sent;
      // Make sure the sender waits for every result at least once.
      settle();
      while (cells_sent < start_cells + RANDOM_CELLS) begin
         gaps_on   = !(cells_sent - start_cells inside {[500:900]});
         stalls_on = gaps_on;
         send_random_matrix();
      end
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
   endtask

   task automatic test_full_square();
      write_row_width(WIDTH_W'(SQUARE_COLS));
      send_cells(SQUARE_COLS * SQUARE_COLS, 100);
   endtask

   initial begin
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      req_bus.valid    <= 1'b0;
      req_bus.cell_req <= 1'b0;
      req_bus.last     <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_column();
      test_register_extremes();
      test_small_squares();
      test_width_change_mid_row();
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      test_width_change_mid_row();
      test_random_matrices();
      test_full_square();
      settle();

      $display("covered %0d cells in %0d matrices, widths 0 to 511, early ends,",
               cells_sent, squares_seen);
      $display("width changes inside a matrix and a solid 16 by 16 square; %0d mismatches",
               errors);
      if (errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
